[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define KNMH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KNMH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/knmh_pkg.sv]
// ----------------------------------------------------------------------------
// knmh_pkg
// Types, widths, codes and the heap ordering for the k-nearest max-heap.
// ----------------------------------------------------------------------------
package knmh_pkg;

  localparam int MAX_CAPACITY = 32;
  localparam int INDEX_BITS   = 20;

  localparam int DIST_W  = 32;
  localparam int PIDX_W  = 20;
  localparam int CAP_W   = 6;
  localparam int COUNT_W = 6;
  localparam int MODE_W  = 2;
  localparam int IDENT_W = (INDEX_BITS < PIDX_W) ? INDEX_BITS : PIDX_W;
  localparam int ADDR_W  = (MAX_CAPACITY > 1) ? $clog2(MAX_CAPACITY) : 1;
  localparam int CNT_W   = $clog2(MAX_CAPACITY + 1);
  localparam int ENTRY_W = DIST_W + IDENT_W;

  typedef logic [DIST_W-1:0]  dist_t;
  typedef logic [IDENT_W-1:0] ident_t;
  typedef logic [PIDX_W-1:0]  pidx_t;
  typedef logic [CAP_W-1:0]   cap_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [ADDR_W+1:0]  child_addr_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  localparam cap_t CAP_RESET = (MAX_CAPACITY > 63) ? cap_t'(63) : cap_t'(MAX_CAPACITY);

  typedef struct packed {
    dist_t  sq_dist;
    ident_t ident;
  } entry_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_CLEAR  = 2'd1,
    MODE_READ   = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_HEAP_LOAD,
    ST_HEAP_TAKE,
    ST_SIFT_RD,
    ST_SIFT_CMP,
    ST_EMIT,
    ST_RD_ADDR,
    ST_RD_EMIT
  } state_t;

  typedef enum logic [1:0] {
    RD_HEAP,
    RD_CHILD,
    RD_SLOT
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_APPEND,
    WR_CHILD,
    WR_ITEM
  } wr_sel_t;

  typedef struct packed {
    logic    cfg_write;
    logic    req_load;
    logic    visit_inc;
    logic    clear;
    logic    held_inc;
    logic    heap_start;
    logic    sift_start;
    logic    heap_take;
    logic    pos_advance;
    logic    heap_dec;
    logic    rd_start;
    logic    rd_next;
    logic    out_load;
    logic    out_entry;
    wr_sel_t wr_sel;
    rd_sel_t rd_sel;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  room;
    logic  fills;
    logic  multi_k;
    logic  beats_root;
    logic  empty;
    logic  leaf;
    logic  child_wins;
    logic  heap_more;
    logic  rd_last;
    logic  out_free;
  } status_t;

  // ordering on (distance, identifier); larger identifier wins a tie
  function automatic logic entry_gt(entry_t a, entry_t b);
    logic gt;
    if (a.sq_dist != b.sq_dist) begin
      gt = (a.sq_dist > b.sq_dist);
    end else begin
      gt = (a.ident > b.ident);
    end
    return gt;
  endfunction

endpackage

[rtl/knmh_ram.sv]
// ----------------------------------------------------------------------------
// knmh_ram
// Generic RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module knmh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                            rdata_a,
  output logic [WIDTH-1:0]                            rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[rtl/knmh_ctrl.sv]
// ----------------------------------------------------------------------------
// knmh_ctrl
// Sequencer for insert, heapify, sift-down, clear and readout.
// ----------------------------------------------------------------------------
module knmh_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  knmh_pkg::status_t  st,
  output knmh_pkg::cmd_t     cmd
);

  knmh_pkg::state_t state;
  knmh_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= knmh_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.wr_sel = knmh_pkg::WR_NONE;
    cmd.rd_sel = knmh_pkg::RD_SLOT;
    in_stall   = 1'b1;
    cfg_ready  = 1'b0;
    case (state)
      knmh_pkg::ST_IDLE: begin
        cfg_ready     = 1'b1;
        in_stall      = cfg_valid;
        cmd.cfg_write = cfg_valid;
        if (in_valid && !cfg_valid) begin
          cmd.req_load = 1'b1;
          state_next   = knmh_pkg::ST_DECODE;
        end
      end
      knmh_pkg::ST_DECODE: begin
        case (st.mode)
          knmh_pkg::MODE_INSERT: begin
            cmd.visit_inc = 1'b1;
            if (st.room) begin
              cmd.wr_sel   = knmh_pkg::WR_APPEND;
              cmd.held_inc = 1'b1;
              if (st.fills && st.multi_k) begin
                cmd.heap_start = 1'b1;
                state_next     = knmh_pkg::ST_HEAP_LOAD;
              end else begin
                state_next = knmh_pkg::ST_EMIT;
              end
            end else if (st.beats_root) begin
              cmd.sift_start = 1'b1;
              state_next     = knmh_pkg::ST_SIFT_RD;
            end else begin
              state_next = knmh_pkg::ST_EMIT;
            end
          end
          knmh_pkg::MODE_CLEAR: begin
            cmd.clear  = 1'b1;
            state_next = knmh_pkg::ST_EMIT;
          end
          knmh_pkg::MODE_READ: begin
            if (st.empty) begin
              state_next = knmh_pkg::ST_EMIT;
            end else begin
              cmd.rd_start = 1'b1;
              state_next   = knmh_pkg::ST_RD_ADDR;
            end
          end
          default: begin
            state_next = knmh_pkg::ST_EMIT;
          end
        endcase
      end
      knmh_pkg::ST_HEAP_LOAD: begin
        cmd.rd_sel = knmh_pkg::RD_HEAP;
        state_next = knmh_pkg::ST_HEAP_TAKE;
      end
      knmh_pkg::ST_HEAP_TAKE: begin
        cmd.heap_take = 1'b1;
        state_next    = knmh_pkg::ST_SIFT_RD;
      end
      knmh_pkg::ST_SIFT_RD: begin
        if (st.leaf) begin
          // no children: drop the carried item in place
          cmd.wr_sel = knmh_pkg::WR_ITEM;
          if (st.heap_more) begin
            cmd.heap_dec = 1'b1;
            state_next   = knmh_pkg::ST_HEAP_LOAD;
          end else begin
            state_next = knmh_pkg::ST_EMIT;
          end
        end else begin
          cmd.rd_sel = knmh_pkg::RD_CHILD;
          state_next = knmh_pkg::ST_SIFT_CMP;
        end
      end
      knmh_pkg::ST_SIFT_CMP: begin
        if (st.child_wins) begin
          cmd.wr_sel      = knmh_pkg::WR_CHILD;
          cmd.pos_advance = 1'b1;
          state_next      = knmh_pkg::ST_SIFT_RD;
        end else begin
          cmd.wr_sel = knmh_pkg::WR_ITEM;
          if (st.heap_more) begin
            cmd.heap_dec = 1'b1;
            state_next   = knmh_pkg::ST_HEAP_LOAD;
          end else begin
            state_next = knmh_pkg::ST_EMIT;
          end
        end
      end
      knmh_pkg::ST_EMIT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = knmh_pkg::ST_IDLE;
        end
      end
      knmh_pkg::ST_RD_ADDR: begin
        state_next = knmh_pkg::ST_RD_EMIT;
      end
      knmh_pkg::ST_RD_EMIT: begin
        if (st.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_entry = 1'b1;
          if (st.rd_last) begin
            state_next = knmh_pkg::ST_IDLE;
          end else begin
            cmd.rd_next = 1'b1;
            state_next  = knmh_pkg::ST_RD_ADDR;
          end
        end
      end
      default: begin
        state_next = knmh_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/knmh_dpath.sv]
// ----------------------------------------------------------------------------
// knmh_dpath
// Heap store, counters, sift registers and the output register.
// ----------------------------------------------------------------------------
module knmh_dpath (
  input  logic                    clk,
  input  logic                    rst,
  input  knmh_pkg::cmd_t          cmd,
  output knmh_pkg::status_t       st,
  input  knmh_pkg::cap_t          capacity,
  input  logic [1:0]              mode,
  input  knmh_pkg::dist_t         dist_sq,
  input  knmh_pkg::pidx_t         photon_index,
  output logic                    out_valid,
  input  logic                    out_stall,
  output knmh_pkg::dist_t         entry_dist_sq,
  output knmh_pkg::pidx_t         entry_index,
  output knmh_pkg::dist_t         search_radius_sq,
  output knmh_pkg::count_t        entry_count,
  output knmh_pkg::dist_t         visited_total,
  output logic                    last
);

  knmh_pkg::cap_t        cap_q;
  knmh_pkg::cnt_t        held;
  knmh_pkg::dist_t       visited;
  knmh_pkg::dist_t       root_dist;
  knmh_pkg::mode_t       req_mode;
  knmh_pkg::entry_t      req_entry;
  knmh_pkg::entry_t      item;
  knmh_pkg::addr_t       pos;
  knmh_pkg::addr_t       heap_i;
  logic                  heapify;
  knmh_pkg::addr_t       rd_i;

  knmh_pkg::cnt_t        k;
  logic                  full;
  knmh_pkg::child_addr_t left_a;
  knmh_pkg::child_addr_t right_a;
  knmh_pkg::child_addr_t n_ext;
  logic                  has_right;
  logic                  pick_right;
  knmh_pkg::entry_t      rd_a;
  knmh_pkg::entry_t      rd_b;
  knmh_pkg::entry_t      child;
  knmh_pkg::addr_t       child_addr;

  logic                  we;
  knmh_pkg::addr_t       waddr;
  knmh_pkg::entry_t      wdata;
  knmh_pkg::addr_t       raddr_a;
  logic                  out_free;

  // capacity zero acts as one, above the store size as the store size
  always_comb begin
    if (cap_q == '0) begin
      k = knmh_pkg::cnt_t'(1);
    end else if (32'(cap_q) > knmh_pkg::MAX_CAPACITY) begin
      k = knmh_pkg::cnt_t'(knmh_pkg::MAX_CAPACITY);
    end else begin
      k = knmh_pkg::cnt_t'(cap_q);
    end
  end

  assign full     = (held >= k);
  assign out_free = !out_valid || !out_stall;

  // children of pos: 2*pos+1 and 2*pos+2
  assign left_a     = knmh_pkg::child_addr_t'({pos, 1'b1});
  assign right_a    = left_a + knmh_pkg::child_addr_t'(1);
  assign n_ext      = knmh_pkg::child_addr_t'(k);
  assign has_right  = (right_a < n_ext);
  assign pick_right = has_right && knmh_pkg::entry_gt(rd_b, rd_a);
  assign child      = pick_right ? rd_b : rd_a;
  assign child_addr = pick_right ? right_a[knmh_pkg::ADDR_W-1:0]
                                 : left_a[knmh_pkg::ADDR_W-1:0];

  always_comb begin
    case (cmd.rd_sel)
      knmh_pkg::RD_HEAP:  raddr_a = heap_i;
      knmh_pkg::RD_CHILD: raddr_a = left_a[knmh_pkg::ADDR_W-1:0];
      default:            raddr_a = rd_i;
    endcase
  end

  always_comb begin
    we    = 1'b1;
    waddr = pos;
    wdata = item;
    case (cmd.wr_sel)
      knmh_pkg::WR_APPEND: begin
        waddr = held[knmh_pkg::ADDR_W-1:0];
        wdata = req_entry;
      end
      knmh_pkg::WR_CHILD: begin
        wdata = child;
      end
      knmh_pkg::WR_ITEM: begin
        wdata = item;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  knmh_ram #(
    .WIDTH (knmh_pkg::ENTRY_W),
    .DEPTH (knmh_pkg::MAX_CAPACITY)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (right_a[knmh_pkg::ADDR_W-1:0]),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_q     <= knmh_pkg::CAP_RESET;
      held      <= '0;
      visited   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.cfg_write) begin
        cap_q <= capacity;
      end
      if (cmd.cfg_write || cmd.clear) begin
        held    <= '0;
        visited <= '0;
      end else begin
        if (cmd.held_inc) begin
          held <= held + knmh_pkg::cnt_t'(1);
        end
        if (cmd.visit_inc && (visited != '1)) begin
          visited <= visited + knmh_pkg::dist_t'(1);
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload and sift registers
  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_mode          <= knmh_pkg::mode_t'(mode);
      req_entry.sq_dist <= dist_sq;
      req_entry.ident   <= knmh_pkg::ident_t'(photon_index);
    end
    if (we && (waddr == '0)) begin
      root_dist <= wdata.sq_dist;
    end
    if (cmd.sift_start) begin
      item    <= req_entry;
      pos     <= '0;
      heapify <= 1'b0;
    end else if (cmd.heap_take) begin
      item <= rd_a;
      pos  <= heap_i;
    end else if (cmd.pos_advance) begin
      pos <= child_addr;
    end
    if (cmd.heap_start) begin
      // last interior node of a full heap
      heap_i  <= knmh_pkg::addr_t'((k >> 1) - knmh_pkg::cnt_t'(1));
      heapify <= 1'b1;
    end else if (cmd.heap_dec) begin
      heap_i <= heap_i - knmh_pkg::addr_t'(1);
    end
    if (cmd.rd_start) begin
      rd_i <= '0;
    end else if (cmd.rd_next) begin
      rd_i <= rd_i + knmh_pkg::addr_t'(1);
    end
    if (cmd.out_load) begin
      entry_dist_sq    <= cmd.out_entry ? rd_a.sq_dist : '0;
      entry_index      <= cmd.out_entry ? knmh_pkg::pidx_t'(rd_a.ident) : '0;
      search_radius_sq <= full ? root_dist : '1;
      entry_count      <= knmh_pkg::count_t'(held);
      visited_total    <= visited;
      last             <= cmd.out_entry ? st.rd_last : 1'b1;
    end
  end

  always_comb begin
    st.mode       = req_mode;
    st.room       = (held < k);
    st.fills      = ((held + knmh_pkg::cnt_t'(1)) == k);
    st.multi_k    = (k > knmh_pkg::cnt_t'(1));
    st.beats_root = (req_entry.sq_dist < root_dist);
    st.empty      = (held == '0);
    st.leaf       = (left_a >= n_ext);
    st.child_wins = knmh_pkg::entry_gt(child, item);
    st.heap_more  = heapify && (heap_i != '0);
    st.rd_last    = ((knmh_pkg::cnt_t'(rd_i) + knmh_pkg::cnt_t'(1)) == held);
    st.out_free   = out_free;
  end

endmodule

[rtl/k_nearest_max_heap_gatherer_core.sv]
// An insert is dropped or appended, or enters a full store and sifts down level by level.
// The insert that fills the store adds Floyd heapify over the interior nodes when K exceeds one.
// Clear and unused mode give a single result each.
// Readout gives one result per held entry, or a single result for an empty store.
// One item at a time, no overlap.
// Reset: synchronous; capacity returns to the store size, store empty.
// ----------------------------------------------------------------------------
// k_nearest_max_heap_gatherer_core
// Keeps the K nearest candidates in a bounded max-heap and reports radius.
// ----------------------------------------------------------------------------
module k_nearest_max_heap_gatherer_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              mode,
  input  knmh_pkg::dist_t         dist_sq,
  input  knmh_pkg::pidx_t         photon_index,
  output logic                    out_valid,
  input  logic                    out_stall,
  output knmh_pkg::dist_t         entry_dist_sq,
  output knmh_pkg::pidx_t         entry_index,
  output knmh_pkg::dist_t         search_radius_sq,
  output knmh_pkg::count_t        entry_count,
  output knmh_pkg::dist_t         visited_total,
  output logic                    last,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  knmh_pkg::cap_t          capacity
);

  knmh_pkg::cmd_t    cmd;
  knmh_pkg::status_t st;

  knmh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .st        (st),
    .cmd       (cmd)
  );

  knmh_dpath u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .st               (st),
    .capacity         (capacity),
    .mode             (mode),
    .dist_sq          (dist_sq),
    .photon_index     (photon_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .entry_dist_sq    (entry_dist_sq),
    .entry_index      (entry_index),
    .search_radius_sq (search_radius_sq),
    .entry_count      (entry_count),
    .visited_total    (visited_total),
    .last             (last)
  );

endmodule

[rtl/knmh_checker.sv]
// ----------------------------------------------------------------------------
// knmh_checker
// Port-level checks on the gatherer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module knmh_checker (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input knmh_pkg::dist_t         entry_dist_sq,
  input knmh_pkg::pidx_t         entry_index,
  input knmh_pkg::dist_t         search_radius_sq,
  input knmh_pkg::count_t        entry_count,
  input knmh_pkg::dist_t         visited_total,
  input logic                    last
);

  `KNMH_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(entry_dist_sq) && $stable(entry_index) && $stable(search_radius_sq) && $stable(entry_count) && $stable(visited_total) && $stable(last), "stalled result changed")

  // one item at a time: busy right after a transfer in
  `KNMH_ASSERT_NXT(a_busy_after_in, in_valid && !in_stall, in_stall, "input taken while busy")

  `KNMH_ASSERT_IMP(a_empty_radius, out_valid && (entry_count == '0), search_radius_sq == '1, "empty store with finite radius")

  `KNMH_ASSERT_IMP(a_multi_needs_entries, out_valid && !last, entry_count != '0, "non-final result without entries")

endmodule

bind k_nearest_max_heap_gatherer_core knmh_checker u_knmh_checker (.*);

[dv/tb_k_nearest_max_heap_gatherer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_k_nearest_max_heap_gatherer_core
// Sends insert, clear, readout and unused-mode requests through the request
// channel with random gaps and output stalls. A shadow copy of the bounded
// max-heap predicts every result transfer, and the results are checked in order.
// ----------------------------------------------------------------------------
module tb_k_nearest_max_heap_gatherer_core;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned IDLE_PCT    = 18;
  localparam int unsigned MAX_SHOWN   = 10;
  localparam int unsigned PHASE_ITEMS = 46;

  typedef struct packed {
    knmh_pkg::dist_t  ent_dist;
    knmh_pkg::pidx_t  ent_idx;
    knmh_pkg::dist_t  radius;
    knmh_pkg::count_t count;
    knmh_pkg::dist_t  visited;
    logic             last_flag;
  } report_t;

  // shadow of the heap store; predicts the result transfers of each request
  class heap_shadow;
    knmh_pkg::dist_t  dist_slot [knmh_pkg::MAX_CAPACITY];
    knmh_pkg::ident_t id_slot   [knmh_pkg::MAX_CAPACITY];
    int unsigned      held;
    knmh_pkg::dist_t  visited;
    knmh_pkg::cap_t   cap_reg;
    report_t          pending_reports [$];
    int unsigned      errors;

    function new();
      for (int s = 0; s < knmh_pkg::MAX_CAPACITY; s++) begin
        dist_slot[s] = '0;
        id_slot[s]   = '0;
      end
      held    = 0;
      visited = '0;
      cap_reg = knmh_pkg::CAP_RESET;
      errors  = 0;
    endfunction

    function int unsigned eff_k();
      if (cap_reg == '0) return 1;
      if (32'(cap_reg) > knmh_pkg::MAX_CAPACITY) return knmh_pkg::MAX_CAPACITY;
      return 32'(cap_reg);
    endfunction

    function bit slot_gt(int unsigned a, int unsigned b);
      if (dist_slot[a] != dist_slot[b]) return dist_slot[a] > dist_slot[b];
      return id_slot[a] > id_slot[b];
    endfunction

    function void swap_slots(int unsigned a, int unsigned b);
      knmh_pkg::dist_t  d;
      knmh_pkg::ident_t i;
      d            = dist_slot[a];
      i            = id_slot[a];
      dist_slot[a] = dist_slot[b];
      id_slot[a]   = id_slot[b];
      dist_slot[b] = d;
      id_slot[b]   = i;
    endfunction

    function void sift_down(int unsigned pos, int unsigned n);
      int unsigned child;
      while (2 * pos + 1 < n) begin
        child = 2 * pos + 1;
        if (child + 1 < n && slot_gt(child + 1, child)) child++;
        if (!slot_gt(child, pos)) break;
        swap_slots(child, pos);
        pos = child;
      end
    endfunction

    function void push_report(knmh_pkg::dist_t ed, knmh_pkg::pidx_t ei, logic fin);
      report_t r;
      r.ent_dist  = ed;
      r.ent_idx   = ei;
      r.radius    = (held >= eff_k()) ? dist_slot[0] : '1;
      r.count     = knmh_pkg::count_t'(held);
      r.visited   = visited;
      r.last_flag = fin;
      pending_reports.insert(pending_reports.size(), r);
    endfunction

    function void write_capacity(knmh_pkg::cap_t v);
      cap_reg = v;
      held    = 0;
      visited = '0;
    endfunction

    function void absorb_request(knmh_pkg::mode_t m, knmh_pkg::dist_t d,
                                 knmh_pkg::pidx_t p);
      int unsigned k;
      int          node;
      k = eff_k();
      case (m)
        knmh_pkg::MODE_INSERT: begin
          if (visited != '1) visited++;
          if (held < k) begin
            dist_slot[held] = d;
            id_slot[held]   = knmh_pkg::ident_t'(p);
            held++;
            // heapify bottom-up once the last free slot fills
            if (held == k) begin
              for (node = k / 2; node > 0; node--) sift_down(node - 1, k);
            end
          end else if (d < dist_slot[0]) begin
            dist_slot[0] = d;
            id_slot[0]   = knmh_pkg::ident_t'(p);
            sift_down(0, held);
          end
          push_report('0, '0, 1'b1);
        end
        knmh_pkg::MODE_CLEAR: begin
          held    = 0;
          visited = '0;
          push_report('0, '0, 1'b1);
        end
        knmh_pkg::MODE_READ: begin
          if (held == 0) begin
            push_report('0, '0, 1'b1);
          end else begin
            for (node = 0; node < held; node++) begin
              push_report(dist_slot[node], knmh_pkg::pidx_t'(id_slot[node]),
                          node + 1 == held);
            end
          end
        end
        default: begin
          push_report('0, '0, 1'b1);
        end
      endcase
    endfunction

    function void match_report(report_t got);
      report_t want;
      if (pending_reports.size() == 0) begin
        if (errors < MAX_SHOWN) begin
          $display("unexpected result transfer: dist %h idx %h radius %h count %0d",
                   got.ent_dist, got.ent_idx, got.radius, got.count);
        end
        errors++;
        return;
      end
      want = pending_reports.pop_front();
      if (got.ent_dist !== want.ent_dist || got.ent_idx !== want.ent_idx ||
          got.radius !== want.radius || got.count !== want.count ||
          got.visited !== want.visited || got.last_flag !== want.last_flag) begin
        if (errors < MAX_SHOWN) begin
          $display("result mismatch: expected dist %h idx %h radius %h count %0d",
                   want.ent_dist, want.ent_idx, want.radius, want.count);
          $display("                 expected visited %0d last %b",
                   want.visited, want.last_flag);
          $display("                 actual   dist %h idx %h radius %h count %0d",
                   got.ent_dist, got.ent_idx, got.radius, got.count);
          $display("                 actual   visited %0d last %b",
                   got.visited, got.last_flag);
        end
        errors++;
      end
    endfunction
  endclass

  logic             clk          = 1'b0;
  logic             rst          = 1'b1;
  logic             in_valid     = 1'b0;
  logic             in_stall;
  logic [1:0]       mode         = knmh_pkg::MODE_INSERT;
  knmh_pkg::dist_t  dist_sq      = '0;
  knmh_pkg::pidx_t  photon_index = '0;
  logic             out_valid;
  logic             out_stall    = 1'b0;
  knmh_pkg::dist_t  entry_dist_sq;
  knmh_pkg::pidx_t  entry_index;
  knmh_pkg::dist_t  search_radius_sq;
  knmh_pkg::count_t entry_count;
  knmh_pkg::dist_t  visited_total;
  logic             last;
  logic             cfg_valid    = 1'b0;
  logic             cfg_ready;
  knmh_pkg::cap_t   capacity     = knmh_pkg::CAP_RESET;

  bit          idle_on  = 1'b1;
  bit          stall_on = 1'b1;
  int unsigned cycle_count = 0;
  heap_shadow  shadow;

  k_nearest_max_heap_gatherer_core DUT (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .mode             (mode),
    .dist_sq          (dist_sq),
    .photon_index     (photon_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .entry_dist_sq    (entry_dist_sq),
    .entry_index      (entry_index),
    .search_radius_sq (search_radius_sq),
    .entry_count      (entry_count),
    .visited_total    (visited_total),
    .last             (last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .capacity         (capacity)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_k_nearest_max_heap_gatherer_core NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= !rst && stall_on && ($urandom_range(0, 99) < IDLE_PCT);
  end

  always @(posedge clk) begin : watch_results
    report_t seen;
    if (!rst && out_valid && !out_stall) begin
      seen.ent_dist  = entry_dist_sq;
      seen.ent_idx   = entry_index;
      seen.radius    = search_radius_sq;
      seen.count     = entry_count;
      seen.visited   = visited_total;
      seen.last_flag = last;
      shadow.match_report(seen);
    end
  end

  function automatic knmh_pkg::dist_t pick_dist();
    knmh_pkg::dist_t d;
    case ($urandom_range(0, 7))
      0:       d = '0;
      1:       d = '1;
      2, 3:    d = knmh_pkg::dist_t'($urandom_range(0, 15));
      default: d = $urandom;
    endcase
    return d;
  endfunction

  function automatic knmh_pkg::pidx_t pick_pidx();
    knmh_pkg::pidx_t p;
    if ($urandom_range(0, 3) == 0) p = knmh_pkg::pidx_t'($urandom_range(0, 3));
    else p = knmh_pkg::pidx_t'($urandom);
    return p;
  endfunction

  // valid stays high after a transfer; the next call either idles or reloads
  task automatic send_item(input knmh_pkg::mode_t m, input knmh_pkg::dist_t d,
                           input knmh_pkg::pidx_t p);
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    mode         <= m;
    dist_sq      <= d;
    photon_index <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    shadow.absorb_request(m, d, p);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (shadow.pending_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_capacity(input knmh_pkg::cap_t v);
    drain();
    cfg_valid <= 1'b1;
    capacity  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    shadow.write_capacity(v);
  endtask

  // mostly clear / fill / read out, with some stray requests mixed in
  task automatic random_phase(input int unsigned budget);
    int unsigned sent;
    int unsigned k;
    int unsigned n;
    sent = 0;
    k    = shadow.eff_k();
    while (sent < budget) begin
      if (budget - sent >= 3 && $urandom_range(0, 99) < 80) begin
        if ($urandom_range(0, 99) < 60) begin
          send_item(knmh_pkg::MODE_CLEAR, pick_dist(), pick_pidx());
          sent++;
        end
        n = $urandom_range(1, k + 6);
        // keep the phase within its budget
        if (n > budget - sent - 1) n = budget - sent - 1;
        repeat (n) send_item(knmh_pkg::MODE_INSERT, pick_dist(), pick_pidx());
        send_item(knmh_pkg::MODE_READ, pick_dist(), pick_pidx());
        sent += n + 1;
      end else begin
        send_item(knmh_pkg::mode_t'($urandom_range(0, 3)), pick_dist(), pick_pidx());
        sent++;
      end
    end
  endtask

  initial begin
    knmh_pkg::cap_t cap_plan [9];
    shadow = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty store, unused mode, field extremes at the reset capacity
    send_item(knmh_pkg::MODE_READ, '1, '1);
    send_item(knmh_pkg::MODE_NOP, '1, '1);
    send_item(knmh_pkg::MODE_INSERT, '1, '1);
    send_item(knmh_pkg::MODE_INSERT, '0, '0);
    send_item(knmh_pkg::MODE_READ, '0, '0);
    send_item(knmh_pkg::MODE_CLEAR, '1, '1);
    send_item(knmh_pkg::MODE_READ, '0, '0);

    // small heap: tie on distance, equal to radius, below radius
    set_capacity(knmh_pkg::cap_t'(3));
    send_item(knmh_pkg::MODE_INSERT, knmh_pkg::dist_t'(100), knmh_pkg::pidx_t'(5));
    send_item(knmh_pkg::MODE_INSERT, knmh_pkg::dist_t'(100), knmh_pkg::pidx_t'(9));
    send_item(knmh_pkg::MODE_INSERT, knmh_pkg::dist_t'(50), knmh_pkg::pidx_t'(1));
    send_item(knmh_pkg::MODE_INSERT, knmh_pkg::dist_t'(100), knmh_pkg::pidx_t'(2));
    send_item(knmh_pkg::MODE_INSERT, knmh_pkg::dist_t'(99), '1);
    send_item(knmh_pkg::MODE_INSERT, '0, knmh_pkg::pidx_t'(7));
    send_item(knmh_pkg::MODE_INSERT, '1, knmh_pkg::pidx_t'(3));
    send_item(knmh_pkg::MODE_READ, '0, '0);
    send_item(knmh_pkg::MODE_NOP, '0, '0);
    send_item(knmh_pkg::MODE_CLEAR, '0, '0);
    send_item(knmh_pkg::MODE_READ, '0, '0);

    cap_plan = '{knmh_pkg::cap_t'(1), knmh_pkg::cap_t'(0), knmh_pkg::cap_t'(63),
                 knmh_pkg::cap_t'(2), knmh_pkg::cap_t'(32), knmh_pkg::cap_t'(7),
                 knmh_pkg::cap_t'(5), knmh_pkg::cap_t'($urandom_range(1, 32)),
                 knmh_pkg::cap_t'(17)};
    foreach (cap_plan[ph]) begin
      set_capacity(cap_plan[ph]);
      // hold both sides busy through one whole phase
      idle_on  = (ph != 4);
      stall_on = (ph != 4);
      random_phase(PHASE_ITEMS);
    end

    drain();
    if (shadow.errors == 0 && shadow.pending_reports.size() == 0) begin
      $display("tb_k_nearest_max_heap_gatherer_core OK");
    end else begin
      $display("tb_k_nearest_max_heap_gatherer_core NOT OK");
    end
    $finish;
  end

endmodule

[k_nearest_max_heap_gatherer_core.f]
+incdir+rtl
rtl/knmh_pkg.sv
rtl/knmh_ram.sv
rtl/knmh_ctrl.sv
rtl/knmh_dpath.sv
rtl/k_nearest_max_heap_gatherer_core.sv
rtl/knmh_checker.sv
dv/tb_k_nearest_max_heap_gatherer_core.sv
